/* sv/sacl_pkg.sv */
package sacl_pkg;

  // Fixed field widths of the tag store and the result counters.
  localparam int TAG_W      = 64;
  localparam int AGE_W      = 3;
  localparam int CNT_W      = 32;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int OUT_DATA_W = 104;

  localparam logic [AGE_W-1:0] AGE_MAX   = 3'd7;
  localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Trace operation codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_FETCH  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_STORE  = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  // One way of a set as held in the tag store.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_entry_t;

  // Counter increment that sticks at the top value.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

/* sv/sacl_tag_store.sv */
module sacl_tag_store #(
  parameter int SET_W    = 6,
  parameter int SETS     = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [SET_W-1:0]                      wr_addr,
  input  sacl_pkg::way_entry_t [MAX_WAYS-1:0]   wr_row,
  input  logic [SET_W-1:0]                      rd_addr,
  output sacl_pkg::way_entry_t [MAX_WAYS-1:0]   rd_row
);

  // One row per set, holding every way of that set.
  sacl_pkg::way_entry_t [MAX_WAYS-1:0] mem [SETS];
  sacl_pkg::way_entry_t [MAX_WAYS-1:0] rd_row_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_row_r <= mem[rd_addr];
  end

  assign rd_row = rd_row_r;

endmodule

/* sv/set_assoc_cache_lru_model.sv */
// A load or store gives its result after a row read, one compare per way in use
// and a write-back; a modify gives a second result in the cycle after the first
// is taken. The shared tag compare serves one item at a time: no new item is
// taken until the results of the last one have been taken.
// An instruction fetch is accepted and gives no result. Reset is synchronous;
// afterwards a clearing pass over all 2^MAX_SET_BITS sets empties the tag store before input.
module set_assoc_cache_lru_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input item.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,   // address[63:0]
  input  logic [sacl_pkg::CMD_W-1:0]          in_tuser,   // cmd[1:0]
  // Result item.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit[0], evicted[1], hit_total[33:2], miss_total[65:34],
  // evict_total[97:66], zero[103:98]
  output logic [sacl_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  // Configuration writes.
  input  logic                                cfg_wr_en,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_READ   = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_UPDATE = 7'b0010000,
    ST_OUT1   = 7'b0100000,
    ST_OUT2   = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [SET_W-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [WAY_W-1:0]                idx_r, idx_nxt;
  logic [2:0]                      cfg_set_bits_r;
  logic [5:0]                      cfg_block_bits_r;
  logic [3:0]                      cfg_ways_r;
  logic [sacl_pkg::CNT_W-1:0]      hits_r, hits_nxt;
  logic [sacl_pkg::CNT_W-1:0]      misses_r, misses_nxt;
  logic [sacl_pkg::CNT_W-1:0]      evicts_r, evicts_nxt;

  // Item working registers.
  sacl_pkg::cmd_t                  cmd_r;
  logic [sacl_pkg::TAG_W-1:0]      tag_r;
  logic [SET_W-1:0]                set_r;
  logic                            hit_found_r;
  logic [WAY_W-1:0]                hit_way_r;
  logic                            empty_found_r;
  logic [WAY_W-1:0]                empty_way_r;
  logic [sacl_pkg::AGE_W-1:0]      oldest_age_r;
  logic [WAY_W-1:0]                oldest_way_r;
  logic                            out_hit_r;
  logic                            out_evict_r;
  logic                            out_last_r;

  logic                                  in_acc;
  logic                                  out_acc;
  logic [2:0]                            s_eff;
  logic [WCNT_W-1:0]                     nways;
  logic [6:0]                            shift_sum;
  logic [sacl_pkg::TAG_W-1:0]            in_tag;
  logic [SET_W:0]                        set_mask;
  logic [SET_W-1:0]                      in_set;
  logic                                  scan_last;
  sacl_pkg::way_entry_t                  cur_way;
  sacl_pkg::way_entry_t [MAX_WAYS-1:0]   rd_row;
  sacl_pkg::way_entry_t [MAX_WAYS-1:0]   new_row;
  sacl_pkg::way_entry_t [MAX_WAYS-1:0]   wr_row;
  logic                                  wr_en;
  logic [SET_W-1:0]                      wr_addr;
  logic [WAY_W-1:0]                      sel_way;
  logic                                  upd_evict;
  logic [sacl_pkg::AGE_W:0]              old_age;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT1) || (state_r == ST_OUT2);
  assign out_acc    = out_tvalid && out_tready;

  // Clamp the configuration to what the store holds.
  always_comb begin
    s_eff = (int'(cfg_set_bits_r) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_set_bits_r;
    if (cfg_ways_r == 4'd0) begin
      nways = WCNT_W'(1);
    end else if (int'(cfg_ways_r) > MAX_WAYS) begin
      nways = WCNT_W'(MAX_WAYS);
    end else begin
      nways = WCNT_W'(cfg_ways_r);
    end
  end

  // Split the incoming address into tag and set index.
  always_comb begin
    shift_sum = {4'd0, s_eff} + {1'b0, cfg_block_bits_r};
    in_tag    = (shift_sum >= 7'd64) ? '0 : (in_tdata >> shift_sum[5:0]);
    set_mask  = ((SET_W + 1)'(1) << s_eff) - (SET_W + 1)'(1);
    in_set    = SET_W'(in_tdata >> cfg_block_bits_r) & set_mask[SET_W-1:0];
  end

  // The shared tag compare looks at one way per cycle.
  assign cur_way   = rd_row[idx_r];
  assign scan_last = ((WCNT_W'(idx_r) + WCNT_W'(1)) == nways);

  // Choose the way to touch and build the written-back row with new ages.
  always_comb begin
    if (hit_found_r) begin
      sel_way = hit_way_r;
    end else if (empty_found_r) begin
      sel_way = empty_way_r;
    end else begin
      sel_way = oldest_way_r;
    end
    upd_evict = !hit_found_r && !empty_found_r;
    old_age   = rd_row[sel_way].valid ? {1'b0, rd_row[sel_way].age}
                                      : {1'b0, sacl_pkg::AGE_MAX} + 4'd1;
    new_row   = rd_row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if ((i < int'(nways)) && (WAY_W'(i) != sel_way) && rd_row[i].valid
          && ({1'b0, rd_row[i].age} < old_age) && (rd_row[i].age != sacl_pkg::AGE_MAX)) begin
        new_row[i].age = rd_row[i].age + 3'd1;
      end
    end
    new_row[sel_way].valid = 1'b1;
    new_row[sel_way].tag   = tag_r;
    new_row[sel_way].age   = '0;
  end

  // Store write port: clearing pass or write-back.
  always_comb begin
    wr_en   = (state_r == ST_CLEAR) || (state_r == ST_UPDATE);
    wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : set_r;
    wr_row  = (state_r == ST_CLEAR) ? '0 : new_row;
  end

  sacl_tag_store #(
    .SET_W    (SET_W),
    .SETS     (SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_addr (set_r),
    .rd_row  (rd_row)
  );

  // Sequencer and counters.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    idx_nxt     = idx_r;
    hits_nxt    = hits_r;
    misses_nxt  = misses_r;
    evicts_nxt  = evicts_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc && (sacl_pkg::cmd_t'(in_tuser) != sacl_pkg::CMD_FETCH)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        idx_nxt = idx_r + WAY_W'(1);
        if (scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (hit_found_r) begin
          hits_nxt = sacl_pkg::sat_inc(hits_r);
        end else begin
          misses_nxt = sacl_pkg::sat_inc(misses_r);
          if (upd_evict) begin
            evicts_nxt = sacl_pkg::sat_inc(evicts_r);
          end
        end
        state_nxt = ST_OUT1;
      end
      ST_OUT1: begin
        if (out_acc) begin
          if (cmd_r == sacl_pkg::CMD_MODIFY) begin
            // The repeat access always hits the line just touched.
            hits_nxt  = sacl_pkg::sat_inc(hits_r);
            state_nxt = ST_OUT2;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT2: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      clr_cnt_r        <= '0;
      idx_r            <= '0;
      hits_r           <= '0;
      misses_r         <= '0;
      evicts_r         <= '0;
      cfg_set_bits_r   <= 3'd0;
      cfg_block_bits_r <= 6'd0;
      cfg_ways_r       <= 4'd1;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      idx_r     <= idx_nxt;
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
      evicts_r  <= evicts_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          sacl_pkg::CFG_SET_BITS:   cfg_set_bits_r   <= cfg_data[2:0];
          sacl_pkg::CFG_BLOCK_BITS: cfg_block_bits_r <= cfg_data;
          sacl_pkg::CFG_WAYS:       cfg_ways_r       <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Item payload and scan results.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= sacl_pkg::cmd_t'(in_tuser);
      tag_r <= in_tag;
      set_r <= in_set;
    end
    if (state_r == ST_READ) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      if (cur_way.valid && (cur_way.tag == tag_r) && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_way_r   <= idx_r;
      end
      if (!cur_way.valid && !empty_found_r) begin
        empty_found_r <= 1'b1;
        empty_way_r   <= idx_r;
      end
      if ((idx_r == '0) || (cur_way.age > oldest_age_r)) begin
        oldest_age_r <= cur_way.age;
        oldest_way_r <= idx_r;
      end
    end
    if (state_r == ST_UPDATE) begin
      out_hit_r   <= hit_found_r;
      out_evict_r <= upd_evict;
      out_last_r  <= (cmd_r != sacl_pkg::CMD_MODIFY);
    end
    if ((state_r == ST_OUT1) && out_acc) begin
      out_hit_r   <= 1'b1;
      out_evict_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tdata = {6'd0, evicts_r, misses_r, hits_r, out_evict_r, out_hit_r};
  assign out_tlast = out_last_r;

endmodule

/* sv/sacl_checker.sv */
module sacl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sacl_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // One item at a time: no input is taken while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // The first result of a modify is followed at once by its closing hit.
  a_modify_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast && out_tdata[0]
      && !out_tdata[1])
    else $error("missing closing hit of a modify");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[1])
    else $error("hit flagged as eviction");

  // Reset leaves no result on the port.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind set_assoc_cache_lru_model sacl_checker u_sacl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
